>>> src/iat_pkg.sv
// Shared types and codes for the indexed array table.
package iat_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned TOTAL_W = 37;

  // Operation codes carried on op_i
  typedef enum logic [2:0] {
    OP_INSERT_AT  = 3'd0,
    OP_APPEND     = 3'd1,
    OP_DELETE_AT  = 3'd2,
    OP_READ       = 3'd3,
    OP_WRITE      = 3'd4,
    OP_LIN_FIND   = 3'd5,
    OP_BIN_FIND   = 3'd6,
    OP_SORTED_INS = 3'd7
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADIDX   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Control of the statistics accumulator
  typedef struct packed {
    logic clr;
    logic en;
    logic first;
  } scan_ctl_t;

endpackage

>>> src/iat_ram.sv
// Generic single-write, single-read RAM with registered read data.
module iat_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, read one word (old data on collision)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/iat_stats.sv
// Running max, exact sum and order check over entries streamed in index order.
module iat_stats (
  input  logic                                   clk_i,
  input  iat_pkg::scan_ctl_t                     ctl_i,
  input  logic signed [iat_pkg::DATA_W-1:0]      data_i,
  output logic signed [iat_pkg::DATA_W-1:0]      max_o,
  output logic signed [iat_pkg::TOTAL_W-1:0]     total_o,
  output logic                                   in_order_o
);

  logic signed [iat_pkg::DATA_W-1:0]  max_q;
  logic signed [iat_pkg::DATA_W-1:0]  prev_q;
  logic signed [iat_pkg::TOTAL_W-1:0] sum_q;
  logic                               ord_q;

  // Clear on a new item, fold in one entry per strobe
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr) begin
      max_q  <= '0;
      prev_q <= '0;
      sum_q  <= '0;
      ord_q  <= 1'b1;
    end else if (ctl_i.en) begin
      if (ctl_i.first || (data_i > max_q)) begin
        max_q <= data_i;
      end
      if (!ctl_i.first && (prev_q > data_i)) begin
        ord_q <= 1'b0;
      end
      sum_q  <= sum_q + iat_pkg::TOTAL_W'(data_i);
      prev_q <= data_i;
    end
  end

  assign max_o      = max_q;
  assign total_o    = sum_q;
  assign in_order_o = ord_q;

endmodule

>>> src/indexed_array_table.sv
// Sequence: from accept to the result strobe an item runs its operation phase, then a rescan
// of all entries held after the item, then the one-cycle strobe; moves and linear probes
// handle one entry at a time, a binary probe reads (S_BIN_RD) then compares (S_BIN_CMP).
// Throughput: one item at a time; busy is high from accept until the strobe cycle, in which
// the next item may start; the receiver cannot stall results.
// Reset clears the fill count, control and result registers; the entry RAM is not cleared.
module indexed_array_table #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [2:0]                           op_i,
  input  logic [iat_pkg::IDX_W-1:0]            index_i,
  input  logic signed [iat_pkg::DATA_W-1:0]    value_i,
  output logic                                 done_o,
  output logic [1:0]                           status_o,
  output logic signed [iat_pkg::DATA_W-1:0]    data_o,
  output logic [iat_pkg::IDX_W-1:0]            position_o,
  output logic [iat_pkg::COUNT_W-1:0]          count_o,
  output logic signed [iat_pkg::DATA_W-1:0]    max_value_o,
  output logic signed [iat_pkg::TOTAL_W-1:0]   total_o,
  output logic                                 in_order_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = (CW > iat_pkg::IDX_W) ? CW : iat_pkg::IDX_W;
  localparam int unsigned BW = CW + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_UP, S_DOWN, S_FETCH, S_LIN, S_BIN_RD, S_BIN_CMP, S_SCAN
  } state_e;

  state_e                         state_q, state_d;
  logic [CW-1:0]                  fill_q, fill_d;
  logic [AW-1:0]                  ptr_q, ptr_d;
  logic [CW-1:0]                  left_q, left_d;
  logic                           rdpend_q, rdpend_d;
  logic [AW-1:0]                  rdaddr_q, rdaddr_d;
  logic [AW-1:0]                  base_q, base_d;
  logic                           sortins_q, sortins_d;
  logic signed [iat_pkg::DATA_W-1:0] val_q, val_d;
  iat_pkg::status_e               status_q, status_d;
  logic signed [iat_pkg::DATA_W-1:0] data_q, data_d;
  logic [AW-1:0]                  pos_q, pos_d;
  logic                           done_q, done_d;
  logic signed [BW-1:0]           lo_q, lo_d;
  logic signed [BW-1:0]           hi_q, hi_d;
  logic [AW-1:0]                  mid_q, mid_d;

  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [iat_pkg::DATA_W-1:0]     mem_wdata;
  logic [AW-1:0]                  mem_raddr;
  logic signed [iat_pkg::DATA_W-1:0] rdata;

  iat_pkg::scan_ctl_t             scan_ctl;

  logic                           full;
  logic [IW-1:0]                  idx_w;
  logic [IW-1:0]                  fill_w;
  logic [AW-1:0]                  idx_a;
  logic                           cmp_eq;
  logic                           cmp_gt;
  logic signed [BW:0]             bin_sum;
  logic signed [BW-1:0]           mid_s;

  iat_ram #(
    .WIDTH (iat_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  iat_stats u_stats (
    .clk_i      (clk_i),
    .ctl_i      (scan_ctl),
    .data_i     (rdata),
    .max_o      (max_value_o),
    .total_o    (total_o),
    .in_order_o (in_order_o)
  );

  // Index checks and the shared key comparator
  assign full    = (fill_q == CW'(DEPTH));
  assign idx_w   = IW'(index_i);
  assign fill_w  = IW'(fill_q);
  assign idx_a   = AW'(idx_w);
  assign cmp_eq  = (rdata == val_q);
  assign cmp_gt  = (rdata > val_q);
  assign bin_sum = (BW + 1)'(lo_q) + (BW + 1)'(hi_q);
  assign mid_s   = $signed(BW'(mid_q));

  // Sequencer next-state logic
  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    ptr_d     = ptr_q;
    left_d    = left_q;
    rdpend_d  = rdpend_q;
    rdaddr_d  = rdaddr_q;
    base_d    = base_q;
    sortins_d = sortins_q;
    val_d     = val_q;
    status_d  = status_q;
    data_d    = data_q;
    pos_d     = pos_q;
    done_d    = 1'b0;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    mem_we    = 1'b0;
    mem_waddr = rdaddr_q;
    mem_wdata = rdata;
    mem_raddr = ptr_q;
    scan_ctl  = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          scan_ctl.clr = 1'b1;
          val_d     = value_i;
          status_d  = iat_pkg::ST_OK;
          data_d    = '0;
          pos_d     = '0;
          sortins_d = 1'b0;
          rdpend_d  = 1'b0;
          ptr_d     = '0;
          left_d    = fill_q;
          state_d   = S_SCAN;
          case (iat_pkg::op_e'(op_i))
            iat_pkg::OP_INSERT_AT: begin
              if (full) begin
                status_d = iat_pkg::ST_FULL;
              end else if (idx_w > fill_w) begin
                status_d = iat_pkg::ST_BADIDX;
              end else begin
                base_d  = idx_a;
                ptr_d   = AW'(fill_q - CW'(1));
                left_d  = CW'(fill_w - idx_w);
                state_d = S_UP;
              end
            end
            iat_pkg::OP_APPEND: begin
              if (full) begin
                status_d = iat_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(fill_q);
                mem_wdata = value_i;
                pos_d     = AW'(fill_q);
                fill_d    = fill_q + CW'(1);
                left_d    = fill_q + CW'(1);
              end
            end
            iat_pkg::OP_DELETE_AT: begin
              if (idx_w >= fill_w) begin
                status_d = iat_pkg::ST_BADIDX;
              end else begin
                base_d  = idx_a;
                ptr_d   = idx_a;
                left_d  = CW'(fill_w - idx_w);
                state_d = S_DOWN;
              end
            end
            iat_pkg::OP_READ: begin
              if (idx_w >= fill_w) begin
                status_d = iat_pkg::ST_BADIDX;
              end else begin
                mem_raddr = idx_a;
                state_d   = S_FETCH;
              end
            end
            iat_pkg::OP_WRITE: begin
              if (idx_w >= fill_w) begin
                status_d = iat_pkg::ST_BADIDX;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = idx_a;
                mem_wdata = value_i;
                pos_d     = idx_a;
              end
            end
            iat_pkg::OP_LIN_FIND: begin
              state_d = S_LIN;
            end
            iat_pkg::OP_BIN_FIND: begin
              lo_d    = '0;
              hi_d    = $signed(BW'(fill_q)) - BW'(1);
              state_d = S_BIN_RD;
            end
            iat_pkg::OP_SORTED_INS: begin
              if (full) begin
                status_d = iat_pkg::ST_FULL;
              end else begin
                base_d    = '0;
                ptr_d     = AW'(fill_q - CW'(1));
                left_d    = fill_q;
                sortins_d = 1'b1;
                state_d   = S_UP;
              end
            end
            default: begin
              status_d = iat_pkg::ST_OK;
            end
          endcase
        end
      end

      // Open a gap: move entries up one slot, highest first
      S_UP: begin
        if (rdpend_q && sortins_q && !cmp_gt) begin
          mem_we    = 1'b1;
          mem_waddr = rdaddr_q + AW'(1);
          mem_wdata = val_q;
          pos_d     = rdaddr_q + AW'(1);
          fill_d    = fill_q + CW'(1);
          ptr_d     = '0;
          left_d    = fill_q + CW'(1);
          rdpend_d  = 1'b0;
          state_d   = S_SCAN;
        end else begin
          if (rdpend_q) begin
            mem_we    = 1'b1;
            mem_waddr = rdaddr_q + AW'(1);
          end
          if (left_q != '0) begin
            rdpend_d = 1'b1;
            rdaddr_d = ptr_q;
            ptr_d    = ptr_q - AW'(1);
            left_d   = left_q - CW'(1);
          end else begin
            rdpend_d = 1'b0;
          end
          if ((left_q == '0) && !rdpend_q) begin
            mem_we    = 1'b1;
            mem_waddr = base_q;
            mem_wdata = val_q;
            pos_d     = base_q;
            fill_d    = fill_q + CW'(1);
            ptr_d     = '0;
            left_d    = fill_q + CW'(1);
            state_d   = S_SCAN;
          end
        end
      end

      // Close a gap: capture the removed entry, move the rest down
      S_DOWN: begin
        if (rdpend_q) begin
          if (rdaddr_q == base_q) begin
            data_d = rdata;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = rdaddr_q - AW'(1);
          end
        end
        if (left_q != '0) begin
          rdpend_d = 1'b1;
          rdaddr_d = ptr_q;
          ptr_d    = ptr_q + AW'(1);
          left_d   = left_q - CW'(1);
        end else begin
          rdpend_d = 1'b0;
        end
        if ((left_q == '0) && !rdpend_q) begin
          fill_d  = fill_q - CW'(1);
          ptr_d   = '0;
          left_d  = fill_q - CW'(1);
          state_d = S_SCAN;
        end
      end

      S_FETCH: begin
        data_d  = rdata;
        ptr_d   = '0;
        left_d  = fill_q;
        state_d = S_SCAN;
      end

      // Walk upward, stop at the lowest matching entry
      S_LIN: begin
        if (rdpend_q && cmp_eq) begin
          pos_d    = rdaddr_q;
          ptr_d    = '0;
          left_d   = fill_q;
          rdpend_d = 1'b0;
          state_d  = S_SCAN;
        end else begin
          if (left_q != '0) begin
            rdpend_d = 1'b1;
            rdaddr_d = ptr_q;
            ptr_d    = ptr_q + AW'(1);
            left_d   = left_q - CW'(1);
          end else begin
            rdpend_d = 1'b0;
          end
          if ((left_q == '0) && !rdpend_q) begin
            status_d = iat_pkg::ST_NOTFOUND;
            ptr_d    = '0;
            left_d   = fill_q;
            state_d  = S_SCAN;
          end
        end
      end

      // Probe the floor midpoint of the current bounds, or report not found once they cross
      S_BIN_RD: begin
        if (lo_q > hi_q) begin
          status_d = iat_pkg::ST_NOTFOUND;
          ptr_d    = '0;
          left_d   = fill_q;
          state_d  = S_SCAN;
        end else begin
          mem_raddr = bin_sum[AW:1];
          mid_d     = bin_sum[AW:1];
          state_d   = S_BIN_CMP;
        end
      end

      S_BIN_CMP: begin
        if (cmp_eq) begin
          pos_d   = mid_q;
          ptr_d   = '0;
          left_d  = fill_q;
          state_d = S_SCAN;
        end else begin
          if (!cmp_gt) begin
            lo_d = mid_s + BW'(1);
          end else begin
            hi_d = mid_s - BW'(1);
          end
          state_d = S_BIN_RD;
        end
      end

      // Stream every valid entry through the statistics unit
      S_SCAN: begin
        if (rdpend_q) begin
          scan_ctl.en    = 1'b1;
          scan_ctl.first = (rdaddr_q == '0);
        end
        if (left_q != '0) begin
          rdpend_d = 1'b1;
          rdaddr_d = ptr_q;
          ptr_d    = ptr_q + AW'(1);
          left_d   = left_q - CW'(1);
        end else begin
          rdpend_d = 1'b0;
        end
        if ((left_q == '0) && !rdpend_q) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state, counters and the result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      ptr_q     <= '0;
      left_q    <= '0;
      rdpend_q  <= 1'b0;
      sortins_q <= 1'b0;
      done_q    <= 1'b0;
      rdaddr_q  <= '0;
      base_q    <= '0;
      val_q     <= '0;
      status_q  <= iat_pkg::ST_OK;
      data_q    <= '0;
      pos_q     <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
      mid_q     <= '0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      ptr_q     <= ptr_d;
      left_q    <= left_d;
      rdpend_q  <= rdpend_d;
      sortins_q <= sortins_d;
      done_q    <= done_d;
      rdaddr_q  <= rdaddr_d;
      base_q    <= base_d;
      val_q     <= val_d;
      status_q  <= status_d;
      data_q    <= data_d;
      pos_q     <= pos_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      mid_q     <= mid_d;
    end
  end

  assign busy       = (state_q != S_IDLE);
  assign done_o     = done_q;
  assign status_o   = status_q;
  assign data_o     = data_q;
  assign position_o = iat_pkg::IDX_W'(pos_q);
  assign count_o    = iat_pkg::COUNT_W'(fill_q);

endmodule

>>> src/iat_checker.sv
// Port-level assertions for the indexed array table, bound to the top level.
module iat_port_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 done_o,
  input logic [1:0]                           status_o,
  input logic signed [iat_pkg::DATA_W-1:0]    data_o,
  input logic [iat_pkg::IDX_W-1:0]            position_o
);

  // An accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting an item");

  // A result strobe lasts one cycle only
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  // A result only follows work in progress
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  // A bad index reports neither data nor position
  a_badidx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == iat_pkg::ST_BADIDX)) |-> ((data_o == '0) && (position_o == '0)))
    else $error("bad index result carries data or position");

endmodule

bind indexed_array_table iat_port_checker u_iat_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .done_o     (done_o),
  .status_o   (status_o),
  .data_o     (data_o),
  .position_o (position_o)
);

>>> sim/iat_checker.sv
// Result checker for the indexed array table: tracks the table and compares every result.
module iat_checker
  import iat_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  input  logic                       busy,
  input  logic [2:0]                 op_i,
  input  logic [IDX_W-1:0]           index_i,
  input  logic signed [DATA_W-1:0]   value_i,
  input  logic                       done_o,
  input  logic [1:0]                 status_o,
  input  logic signed [DATA_W-1:0]   data_o,
  input  logic [IDX_W-1:0]           position_o,
  input  logic [COUNT_W-1:0]         count_o,
  input  logic signed [DATA_W-1:0]   max_value_o,
  input  logic signed [TOTAL_W-1:0]  total_o,
  input  logic                       in_order_o,
  output int                         fail_count_o,
  output int                         pending_o
);

  typedef struct {
    status_e                   status;
    logic signed [DATA_W-1:0]  data;
    logic [IDX_W-1:0]          position;
    logic [COUNT_W-1:0]        count;
    logic signed [DATA_W-1:0]  max_value;
    logic signed [TOTAL_W-1:0] total;
    logic                      in_order;
  } table_result_t;

  // Shadow copy of the table contents and its fill count
  logic signed [DATA_W-1:0] shadow_entries [DEPTH];
  int unsigned              shadow_fill;

  table_result_t expected_results [$];

  // Carry out one operation on the shadow table and return the result it gives
  function automatic table_result_t apply_table_op(input op_e op,
                                                   input logic [IDX_W-1:0] idx,
                                                   input logic signed [DATA_W-1:0] val);
    table_result_t            res;
    int unsigned              i;
    int                       lo;
    int                       hi;
    int                       mid;
    longint                   sum;
    logic signed [DATA_W-1:0] mx;
    logic                     ordered;
    res.status   = ST_OK;
    res.data     = '0;
    res.position = '0;
    case (op)
      OP_INSERT_AT: begin
        if (shadow_fill >= DEPTH) res.status = ST_FULL;
        else if (idx > shadow_fill) res.status = ST_BADIDX;
        else begin
          for (i = shadow_fill; i > idx; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[idx] = val;
          shadow_fill++;
          res.position = idx;
        end
      end
      OP_APPEND: begin
        if (shadow_fill >= DEPTH) res.status = ST_FULL;
        else begin
          shadow_entries[shadow_fill] = val;
          res.position = IDX_W'(shadow_fill);
          shadow_fill++;
        end
      end
      OP_DELETE_AT: begin
        if (idx >= shadow_fill) res.status = ST_BADIDX;
        else begin
          res.data = shadow_entries[idx];
          for (i = idx; i + 1 < shadow_fill; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_fill--;
        end
      end
      OP_READ: begin
        if (idx >= shadow_fill) res.status = ST_BADIDX;
        else res.data = shadow_entries[idx];
      end
      OP_WRITE: begin
        if (idx >= shadow_fill) res.status = ST_BADIDX;
        else begin
          shadow_entries[idx] = val;
          res.position = idx;
        end
      end
      OP_LIN_FIND: begin
        res.status = ST_NOTFOUND;
        for (i = 0; i < shadow_fill; i++) begin
          if (shadow_entries[i] == val) begin
            res.status   = ST_OK;
            res.position = IDX_W'(i);
            break;
          end
        end
      end
      OP_BIN_FIND: begin
        // Plain floor-midpoint loop; runs the same way on an unsorted table
        res.status = ST_NOTFOUND;
        lo = 0;
        hi = int'(shadow_fill) - 1;
        while (lo <= hi) begin
          mid = (lo + hi) / 2;
          if (shadow_entries[mid] == val) begin
            res.status   = ST_OK;
            res.position = IDX_W'(mid);
            break;
          end
          if (shadow_entries[mid] < val) lo = mid + 1;
          else hi = mid - 1;
        end
      end
      OP_SORTED_INS: begin
        // Equal keys stay ahead of the new entry
        if (shadow_fill >= DEPTH) res.status = ST_FULL;
        else begin
          i = shadow_fill;
          while (i > 0 && shadow_entries[i-1] > val) begin
            shadow_entries[i] = shadow_entries[i-1];
            i--;
          end
          shadow_entries[i] = val;
          res.position = IDX_W'(i);
          shadow_fill++;
        end
      end
    endcase

    // Rescan the valid entries for the statistics
    mx      = '0;
    sum     = 0;
    ordered = 1'b1;
    for (i = 0; i < shadow_fill; i++) begin
      if (i == 0 || shadow_entries[i] > mx) mx = shadow_entries[i];
      sum += shadow_entries[i];
      if (i > 0 && shadow_entries[i-1] > shadow_entries[i]) ordered = 1'b0;
    end
    res.count     = COUNT_W'(shadow_fill);
    res.max_value = mx;
    res.total     = TOTAL_W'(sum);
    res.in_order  = ordered;
    return res;
  endfunction

  task automatic flag_mismatch(input string field, input longint want_v, input longint got_v);
    $error("%s: expected %0d, got %0d", field, want_v, got_v);
    fail_count_o++;
  endtask

  // Compare each strobed result with the oldest outstanding item, then log new items
  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t want;
    if (!rst_ni) begin
      shadow_fill  = 0;
      expected_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          $error("result strobe with no item outstanding");
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (status_o !== want.status) flag_mismatch("status", want.status, status_o);
          if (data_o !== want.data) flag_mismatch("data", want.data, data_o);
          if (position_o !== want.position)
            flag_mismatch("position", want.position, position_o);
          if (count_o !== want.count) flag_mismatch("count", want.count, count_o);
          if (max_value_o !== want.max_value)
            flag_mismatch("max_value", want.max_value, max_value_o);
          if (total_o !== want.total) flag_mismatch("total", want.total, total_o);
          if (in_order_o !== want.in_order)
            flag_mismatch("in_order", want.in_order, in_order_o);
        end
      end
      if (start && !busy)
        expected_results.push_back(apply_table_op(op_e'(op_i), index_i, value_i));
      pending_o = expected_results.size();
    end
  end

endmodule

>>> sim/tb_top.sv
// Testbench top for the indexed array table: clock, reset, item stimulus and verdict.
module tb_top;
  import iat_pkg::*;

  localparam int unsigned DEPTH       = 32;
  localparam int          ITEM_TARGET = 1150;
  localparam int          CALM_TAIL   = 100;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          DRAIN_WAIT  = 2 * DEPTH + 16;

  typedef enum {MODE_GROW, MODE_SHRINK, MODE_SORTED, MODE_MIXED} stim_mode_e;

  logic                       clk_i;
  logic                       rst_ni      = 1'b0;
  logic                       start       = 1'b0;
  logic                       busy;
  logic [2:0]                 op_i        = '0;
  logic [IDX_W-1:0]           index_i     = '0;
  logic signed [DATA_W-1:0]   value_i     = '0;
  logic                       done_o;
  logic [1:0]                 status_o;
  logic signed [DATA_W-1:0]   data_o;
  logic [IDX_W-1:0]           position_o;
  logic [COUNT_W-1:0]         count_o;
  logic signed [DATA_W-1:0]   max_value_o;
  logic signed [TOTAL_W-1:0]  total_o;
  logic                       in_order_o;

  int                         fail_count;
  int                         pending;
  int                         items_sent    = 0;
  int                         cycle_count   = 0;
  int unsigned                observed_fill = 0;
  logic signed [DATA_W-1:0]   recent_values [$];

  indexed_array_table #(.DEPTH(DEPTH)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .op_i        (op_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .data_o      (data_o),
    .position_o  (position_o),
    .count_o     (count_o),
    .max_value_o (max_value_o),
    .total_o     (total_o),
    .in_order_o  (in_order_o)
  );

  iat_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .op_i         (op_i),
    .index_i      (index_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .data_o       (data_o),
    .position_o   (position_o),
    .count_o      (count_o),
    .max_value_o  (max_value_o),
    .total_o      (total_o),
    .in_order_o   (in_order_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Track the fill count reported by the block to steer indexes
  always @(posedge clk_i) begin
    if (done_o) observed_fill <= count_o;
  end

  // Stop a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("indexed_array_table regression: fail");
    $finish;
  end

  // Present one item and hold it until the block takes it
  task automatic issue(input op_e op, input logic [IDX_W-1:0] idx,
                       input logic signed [DATA_W-1:0] val);
    start   <= 1'b1;
    op_i    <= op;
    index_i <= idx;
    value_i <= val;
    do @(posedge clk_i); while (busy);
    items_sent++;
    recent_values.push_back(val);
    if (recent_values.size() > 16) void'(recent_values.pop_front());
  endtask

  // Drop start for a short burst now and then
  task automatic maybe_idle(input bit gaps_on);
    if (gaps_on && items_sent < ITEM_TARGET - CALM_TAIL && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return $urandom;
    if (sel < 65) return $urandom_range(0, 8) - 4;
    if (sel < 75) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return -1;
        default: return 0;
      endcase
    end
    if (recent_values.size() == 0) return $urandom;
    return recent_values[$urandom_range(0, recent_values.size() - 1)];
  endfunction

  // Mostly valid positions, sometimes anything the field holds
  function automatic logic [IDX_W-1:0] pick_index(input bit allow_end);
    int unsigned top;
    if ($urandom_range(0, 9) < 3) return IDX_W'($urandom_range(0, 31));
    top = allow_end ? observed_fill : (observed_fill == 0 ? 0 : observed_fill - 1);
    if (top > 31) top = 31;
    return IDX_W'($urandom_range(0, top));
  endfunction

  function automatic op_e pick_op(input stim_mode_e mode);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    case (mode)
      MODE_GROW: begin
        if (sel < 30) return OP_APPEND;
        if (sel < 55) return OP_INSERT_AT;
        if (sel < 70) return OP_SORTED_INS;
      end
      MODE_SHRINK: begin
        if (sel < 55) return OP_DELETE_AT;
        if (sel < 70) return OP_READ;
        if (sel < 80) return OP_WRITE;
      end
      MODE_SORTED: begin
        // Only ops that keep a sorted table sorted
        if (sel < 45) return OP_SORTED_INS;
        if (sel < 70) return OP_BIN_FIND;
        if (sel < 80) return OP_LIN_FIND;
        if (sel < 90) return OP_DELETE_AT;
        return OP_READ;
      end
      default: ;
    endcase
    return op_e'($urandom_range(0, 7));
  endfunction

  // Run one stretch of random items in the given mode
  task automatic run_block(input stim_mode_e mode, input int n_items, input bit gaps_on);
    op_e op;
    int  k;
    if (mode == MODE_SORTED) begin
      // Empty the table first so that sorted inserts build an ordered table
      for (k = 0; k < DEPTH + 2 && observed_fill != 0; k++) begin
        issue(OP_DELETE_AT, '0, pick_value());
        maybe_idle(gaps_on);
      end
    end
    for (k = 0; k < n_items && items_sent < ITEM_TARGET; k++) begin
      op = pick_op(mode);
      issue(op, pick_index(op == OP_INSERT_AT), pick_value());
      maybe_idle(gaps_on);
    end
  endtask

  initial begin
    stim_mode_e mode;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, extremes, order and error cases
    issue(OP_READ,       5'd0,  32'sd0);
    issue(OP_DELETE_AT,  5'd0,  32'sd0);
    issue(OP_WRITE,      5'd0,  32'sd9);
    issue(OP_LIN_FIND,   5'd0,  32'sd5);
    issue(OP_BIN_FIND,   5'd0,  32'sd5);
    issue(OP_INSERT_AT,  5'd1,  32'sd3);
    issue(OP_INSERT_AT,  5'd0,  32'sh8000_0000);
    issue(OP_APPEND,     5'd31, 32'sh7fff_ffff);
    issue(OP_INSERT_AT,  5'd1,  32'sd0);
    issue(OP_SORTED_INS, 5'd0,  -32'sd1);
    issue(OP_SORTED_INS, 5'd0,  32'sh7fff_ffff);
    issue(OP_LIN_FIND,   5'd0,  32'sd0);
    issue(OP_BIN_FIND,   5'd0,  32'sh7fff_ffff);
    issue(OP_READ,       5'd4,  32'sd0);
    issue(OP_READ,       5'd5,  32'sd0);
    issue(OP_WRITE,      5'd0,  -32'sd5);
    issue(OP_WRITE,      5'd4,  -32'sd7);
    issue(OP_BIN_FIND,   5'd0,  -32'sd7);
    issue(OP_LIN_FIND,   5'd0,  32'sd12345);
    issue(OP_WRITE,      5'd31, -32'sd1);
    issue(OP_DELETE_AT,  5'd4,  32'sd0);
    issue(OP_DELETE_AT,  5'd0,  32'sd0);
    issue(OP_INSERT_AT,  5'd31, 32'sd1);

    // Random stretches in shifting modes, some without gaps
    while (items_sent < ITEM_TARGET) begin
      mode = stim_mode_e'($urandom_range(0, 3));
      run_block(mode, $urandom_range(20, 60), $urandom_range(0, 3) != 0);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("indexed_array_table regression: pass");
    end else begin
      $display("indexed_array_table regression: fail");
    end
    $finish;
  end

endmodule
